/* design/mvpid_pkg.sv */
// ----------------------------------------------------------------------------
// Motor velocity PID package
// Shared widths, register map, reset values and constants of the wheel
// velocity PID core.
// ----------------------------------------------------------------------------
package mvpid_pkg;

   // default build parameters
   localparam int DRIVE_LIMIT_DEF = 255;
   localparam int COUNT_BITS_DEF  = 16;

   // stream payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_GAIN     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PREFILTER_COEF = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAD_PER_COUNT  = 3'd4;

   localparam logic [15:0] PROP_GAIN_RST      = 16'd1321;
   localparam logic [15:0] INTEG_GAIN_RST     = 16'd19200;
   localparam logic [15:0] DERIV_GAIN_RST     = 16'd0;
   localparam logic [8:0]  PREFILTER_COEF_RST = 9'd46;
   localparam logic [15:0] RAD_PER_COUNT_RST  = 16'd667;

   // prefilter weight saturates at one
   localparam logic [8:0] COEF_MAX = 9'd256;

   // interval limits in milliseconds
   localparam int MS_W = 10;
   localparam logic [MS_W-1:0] MS_MIN   = 10'd10;
   localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;

   // shared multiplier operands and product
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // divider radix: quotient bits per cycle
   localparam int DIV_STEPS = 4;

   // datapath widths
   localparam int FILT_W   = 24;
   localparam int ERR_W    = 32;
   localparam int NI_W     = 34;
   localparam int X_W      = 34;
   localparam int DIFF_W   = 41;
   localparam int ACC_W    = 60;
   localparam int EXCESS_W = 16;
   localparam int GAIN_SH  = 24;

endpackage

/* design/motor_velocity_pid_antiwindup_core.sv */
// ----------------------------------------------------------------------------
// Motor velocity PID core with anti-windup
// One wheel velocity loop: setpoint prefilter, speed from encoder counts,
// incremental PID into a clamped drive level, PWM duty and direction out.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one control step per transaction: target speed, encoder
//   count and elapsed milliseconds. rsp_* returns one transaction per step
//   with PWM duty, direction and the clamp flag. csr_* writes the gains, the
//   prefilter weight and the radians-per-count scale; write them only while
//   the core is idle.
//   A step with fewer than 10 ms is answered from the held drive level
//   in the hold state, touching no loop state. In a full step, four
//   divisions run on one radix-16 divider with a narrow divisor, and the
//   products come from one shared 17x34 multiplier.
//   req_tready is high only while the sequencer is idle. The result sits in
//   an output register, so the next step is accepted while it waits; a
//   stalled receiver holds the sequencer at its last state until the output
//   register frees up. Only the filtered target is updated before that; the
//   rest of the loop state is committed together with the result.
//   Reset clears the loop state and the output valid and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module motor_velocity_pid_antiwindup_core
   import mvpid_pkg::*;
#(
   parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // target_speed[15:0], encoder_count[31:16], elapsed_ms[41:32]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // pwm_duty[7:0], reverse_dir[8], clamped[9]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // derived widths
   localparam int LVL_W   = $clog2(DRIVE_LIMIT + 1) + 1;
   localparam int DIV_W   = (COUNT_BITS + 25 > 42) ? COUNT_BITS + 25 : 42;
   localparam int DIV_CYC = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIVP    = DIV_CYC * DIV_STEPS;
   localparam int DVW     = DIVP + 1;
   localparam int EW      = DVW + 1;
   localparam int DCNT_W  = $clog2(DIV_CYC + 1);
   localparam int FD_W    = FILT_W + 1;
   localparam int INC_W   = ACC_W - GAIN_SH;
   localparam int SUM_W   = INC_W + 1;
   localparam int EX_W    = SUM_W + 1;

   localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(DRIVE_LIMIT);
   localparam logic signed [SUM_W-1:0] LIM_N = -LIM_P;
   localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
   localparam logic signed [EXCESS_W-1:0] EXC_MAX = {1'b0, {(EXCESS_W-1){1'b1}}};
   localparam logic signed [EXCESS_W-1:0] EXC_MIN = {1'b1, {(EXCESS_W-1){1'b0}}};

   // sequencer states
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_HOLD = 5'd1;
   localparam logic [4:0] ST_FILT = 5'd2;
   localparam logic [4:0] ST_FADD = 5'd3;
   localparam logic [4:0] ST_SPDN = 5'd4;
   localparam logic [4:0] ST_SPDW = 5'd5;
   localparam logic [4:0] ST_ERR  = 5'd6;
   localparam logic [4:0] ST_INTN = 5'd7;
   localparam logic [4:0] ST_INTW = 5'd8;
   localparam logic [4:0] ST_DIFN = 5'd9;
   localparam logic [4:0] ST_DIFW = 5'd10;
   localparam logic [4:0] ST_EXM  = 5'd11;
   localparam logic [4:0] ST_EXN  = 5'd12;
   localparam logic [4:0] ST_EXW  = 5'd13;
   localparam logic [4:0] ST_KP   = 5'd14;
   localparam logic [4:0] ST_KIL  = 5'd15;
   localparam logic [4:0] ST_KIH  = 5'd16;
   localparam logic [4:0] ST_KDL  = 5'd17;
   localparam logic [4:0] ST_KDH  = 5'd18;
   localparam logic [4:0] ST_SUM  = 5'd19;
   localparam logic [4:0] ST_LVL  = 5'd20;

   // control and configuration registers
   logic [4:0]             st_ff, st_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, rpc_ff, rpc_in;
   logic [8:0]             coef_ff, coef_in;

   // loop state
   logic signed [FILT_W-1:0]   filt_ff, filt_in;
   logic [COUNT_BITS-1:0]      last_count_ff, last_count_in;
   logic signed [ERR_W-1:0]    integ_ff, integ_in;
   logic signed [ERR_W-1:0]    last_err_ff, last_err_in;
   logic signed [LVL_W-1:0]    level_ff, level_in;
   logic                       pend_ff, pend_in;
   logic signed [EXCESS_W-1:0] excess_ff, excess_in;

   // step operands and work registers
   logic signed [15:0]         tgt_ff, tgt_in;
   logic [COUNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [MS_W-1:0]            ms_ff, ms_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [ERR_W-1:0]    nint_ff, nint_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [X_W-1:0]      x_ff, x_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [MUL_P_W-1:0]  prod_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   // divider registers
   logic [DIVP-1:0]            dquo_ff, dquo_in;
   logic [MS_W-1:0]            drem_ff, drem_in;
   logic [MS_W-1:0]            dden_ff, dden_in;
   logic                       dneg_ff, dneg_in;
   logic [DCNT_W-1:0]          dcnt_ff, dcnt_in;

   // shared unit hookup
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic                       div_start;
   logic signed [DVW-1:0]      div_num;
   logic [MS_W-1:0]            div_den;
   logic [MS_W-1:0]            div_rem_nx;
   logic [DIVP-1:0]            div_quo_nx;
   logic signed [DVW-1:0]      div_q;
   logic                       div_done;
   logic                       out_free;

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_done   = (dcnt_ff == '0);
   assign div_q      = dneg_ff ? -signed'({1'b0, dquo_ff}) : signed'({1'b0, dquo_ff});

   // advance the divider by DIV_STEPS restoring steps
   always_comb begin : div_iter
      logic [MS_W:0]   r;
      logic [DIVP-1:0] q;
      r = {1'b0, drem_ff};
      q = dquo_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r = {r[MS_W-1:0], q[DIVP-1]};
         q = {q[DIVP-2:0], 1'b0};
         if (r >= {1'b0, dden_ff}) begin
            r    = r - {1'b0, dden_ff};
            q[0] = 1'b1;
         end
      end
      div_rem_nx = r[MS_W-1:0];
      div_quo_nx = q;
   end

   // load or step the divider
   always_comb begin : div_ctrl
      logic signed [DVW-1:0] mag;
      mag     = div_num[DVW-1] ? -div_num : div_num;
      dquo_in = dquo_ff;
      drem_in = drem_ff;
      dden_in = dden_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      if (div_start) begin
         dquo_in = mag[DIVP-1:0];
         drem_in = '0;
         dden_in = div_den;
         dneg_in = div_num[DVW-1];
         dcnt_in = DCNT_W'(DIV_CYC);
      end else if (!div_done) begin
         dquo_in = div_quo_nx;
         drem_in = div_rem_nx;
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   // sequencer, operand selection and state update
   always_comb begin : seq
      logic [8:0]              coef_sat;
      logic signed [FD_W-1:0]  fdiff;
      logic signed [MUL_P_W-1:0] fq;
      logic signed [COUNT_BITS-1:0] delta;
      logic signed [DVW-1:0]   pw;
      logic signed [EW-1:0]    e;
      logic signed [NI_W-1:0]  ni;
      logic signed [ERR_W:0]   de;
      logic signed [ACC_W-1:0] accq;
      logic signed [INC_W-1:0] inc;
      logic signed [SUM_W-1:0] lvl;
      logic signed [SUM_W-1:0] lvl_c;
      logic signed [EX_W-1:0]  ex;
      logic signed [LVL_W-1:0] lv_out;
      logic [LVL_W-1:0]        mag;
      logic [7:0]              pwm;
      logic                    clamp;

      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      kp_in = kp_ff; ki_in = ki_ff; kd_in = kd_ff; rpc_in = rpc_ff; coef_in = coef_ff;
      filt_in       = filt_ff;
      last_count_in = last_count_ff;
      integ_in      = integ_ff;
      last_err_in   = last_err_ff;
      level_in      = level_ff;
      pend_in       = pend_ff;
      excess_in     = excess_ff;
      tgt_in = tgt_ff; cnt_in = cnt_ff; ms_in = ms_ff;
      err_in = err_ff; nint_in = nint_ff; diff_in = diff_ff; x_in = x_ff; acc_in = acc_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = ms_ff;

      coef_sat = (coef_ff > COEF_MAX) ? COEF_MAX : coef_ff;
      fdiff    = FD_W'(signed'({tgt_ff, 8'h00})) - FD_W'(filt_ff);
      fq       = (prod_ff + (prod_ff[MUL_P_W-1] ? MUL_P_W'(255) : MUL_P_W'(0))) >>> 8;
      delta    = signed'(cnt_ff - last_count_ff);
      pw       = DVW'(prod_ff);
      e        = EW'(filt_ff) - EW'(div_q);
      ni       = NI_W'(integ_ff) + NI_W'(div_q);
      de       = (ERR_W+1)'(err_ff) - (ERR_W+1)'(last_err_ff);
      accq     = (acc_ff + (acc_ff[ACC_W-1] ? ACC_W'((64'd1 << GAIN_SH) - 64'd1)
                                            : ACC_W'(0))) >>> GAIN_SH;
      inc      = INC_W'(accq);
      lvl      = SUM_W'(level_ff) + SUM_W'(inc);
      lvl_c    = lvl;
      ex       = '0;
      clamp    = 1'b0;
      if (lvl > LIM_P) begin
         clamp = 1'b1;
         lvl_c = LIM_P;
         ex    = EX_W'(LIM_P) - EX_W'(lvl);
      end else if (lvl < LIM_N) begin
         clamp = 1'b1;
         lvl_c = LIM_N;
         ex    = EX_W'(LIM_N) - EX_W'(lvl);
      end

      // result fields from the level shown in this transaction
      lv_out = (st_ff == ST_LVL) ? LVL_W'(lvl_c) : level_ff;
      mag    = lv_out[LVL_W-1] ? unsigned'(-lv_out) : unsigned'(lv_out);
      pwm    = (mag > 255) ? 8'hFF : 8'(mag);

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PROP_GAIN:      kp_in   = csr_wdata;
            CSR_INTEG_GAIN:     ki_in   = csr_wdata;
            CSR_DERIV_GAIN:     kd_in   = csr_wdata;
            CSR_PREFILTER_COEF: coef_in = csr_wdata[8:0];
            CSR_RAD_PER_COUNT:  rpc_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tgt_in = signed'(req_tdata[15:0]);
               cnt_in = COUNT_BITS'(signed'(req_tdata[31:16]));
               ms_in  = req_tdata[41:32];
               st_in  = (req_tdata[41:32] < MS_MIN) ? ST_HOLD : ST_FILT;
            end
         end
         ST_HOLD: begin
            // short interval: show the held level, touch nothing
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({1'b0, lv_out[LVL_W-1], pwm});
               st_in        = ST_IDLE;
            end
         end
         ST_FILT: begin
            mul_a = signed'(MUL_A_W'(coef_sat));
            mul_b = MUL_B_W'(fdiff);
            st_in = ST_FADD;
         end
         ST_FADD: begin
            filt_in = filt_ff + FILT_W'(fq);
            mul_a   = signed'(MUL_A_W'(rpc_ff));
            mul_b   = MUL_B_W'(delta);
            st_in   = ST_SPDN;
         end
         ST_SPDN: begin
            // speed numerator: count delta * scale * 1000
            div_start = 1'b1;
            div_num   = (pw <<< 10) - (pw <<< 4) - (pw <<< 3);
            div_den   = ms_ff;
            st_in     = ST_SPDW;
         end
         ST_SPDW: begin
            if (div_done) begin
               if (e > EW'(ERR_MAX))      err_in = ERR_MAX;
               else if (e < EW'(ERR_MIN)) err_in = ERR_MIN;
               else                       err_in = ERR_W'(e);
               st_in = ST_ERR;
            end
         end
         ST_ERR: begin
            mul_a = signed'(MUL_A_W'(ms_ff));
            mul_b = MUL_B_W'(err_ff);
            st_in = ST_INTN;
         end
         ST_INTN: begin
            div_start = 1'b1;
            div_num   = pw;
            div_den   = MS_PER_S;
            st_in     = ST_INTW;
         end
         ST_INTW: begin
            if (div_done) begin
               if (ni > NI_W'(ERR_MAX))      nint_in = ERR_MAX;
               else if (ni < NI_W'(ERR_MIN)) nint_in = ERR_MIN;
               else                          nint_in = ERR_W'(ni);
               st_in = ST_DIFN;
            end
         end
         ST_DIFN: begin
            // derivative numerator: error change * 1000
            div_start = 1'b1;
            div_num   = (DVW'(de) <<< 10) - (DVW'(de) <<< 4) - (DVW'(de) <<< 3);
            div_den   = ms_ff;
            st_in     = ST_DIFW;
         end
         ST_DIFW: begin
            if (div_done) begin
               diff_in = DIFF_W'(div_q);
               st_in   = ST_EXM;
            end
         end
         ST_EXM: begin
            mul_a = signed'(MUL_A_W'(ms_ff));
            mul_b = MUL_B_W'(excess_ff);
            st_in = ST_EXN;
         end
         ST_EXN: begin
            div_start = 1'b1;
            div_num   = pw <<< 16;
            div_den   = MS_PER_S;
            st_in     = ST_EXW;
         end
         ST_EXW: begin
            if (div_done) begin
               x_in  = X_W'(nint_ff) + (pend_ff ? X_W'(div_q) : X_W'(0));
               st_in = ST_KP;
            end
         end
         ST_KP: begin
            acc_in = '0;
            mul_a  = signed'({1'b0, kp_ff});
            mul_b  = MUL_B_W'(err_ff);
            st_in  = ST_KIL;
         end
         ST_KIL: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_a  = signed'({1'b0, ki_ff});
            mul_b  = MUL_B_W'(signed'({1'b0, x_ff[GAIN_SH-1:0]}));
            st_in  = ST_KIH;
         end
         ST_KIH: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_a  = signed'({1'b0, ki_ff});
            mul_b  = MUL_B_W'(x_ff >>> GAIN_SH);
            st_in  = ST_KDL;
         end
         ST_KDL: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) <<< GAIN_SH);
            mul_a  = signed'({1'b0, kd_ff});
            mul_b  = MUL_B_W'(signed'({1'b0, diff_ff[GAIN_SH-1:0]}));
            st_in  = ST_KDH;
         end
         ST_KDH: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_a  = signed'({1'b0, kd_ff});
            mul_b  = MUL_B_W'(diff_ff >>> GAIN_SH);
            st_in  = ST_SUM;
         end
         ST_SUM: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) <<< GAIN_SH);
            st_in  = ST_LVL;
         end
         ST_LVL: begin
            // commit the step once the output register can take it
            if (out_free) begin
               last_err_in   = err_ff;
               last_count_in = cnt_ff;
               level_in      = LVL_W'(lvl_c);
               pend_in       = clamp;
               if (clamp) begin
                  if (ex > EX_W'(EXC_MAX))      excess_in = EXC_MAX;
                  else if (ex < EX_W'(EXC_MIN)) excess_in = EXC_MIN;
                  else                          excess_in = EXCESS_W'(ex);
               end else begin
                  integ_in = nint_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({clamp, lv_out[LVL_W-1], pwm});
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // control, configuration and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         dcnt_ff       <= '0;
         kp_ff         <= PROP_GAIN_RST;
         ki_ff         <= INTEG_GAIN_RST;
         kd_ff         <= DERIV_GAIN_RST;
         coef_ff       <= PREFILTER_COEF_RST;
         rpc_ff        <= RAD_PER_COUNT_RST;
         filt_ff       <= '0;
         last_count_ff <= '0;
         integ_ff      <= '0;
         last_err_ff   <= '0;
         level_ff      <= '0;
         pend_ff       <= 1'b0;
         excess_ff     <= '0;
      end else begin
         st_ff         <= st_in;
         rsp_valid_ff  <= rsp_valid_in;
         dcnt_ff       <= dcnt_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         coef_ff       <= coef_in;
         rpc_ff        <= rpc_in;
         filt_ff       <= filt_in;
         last_count_ff <= last_count_in;
         integ_ff      <= integ_in;
         last_err_ff   <= last_err_in;
         level_ff      <= level_in;
         pend_ff       <= pend_in;
         excess_ff     <= excess_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
      tgt_ff      <= tgt_in;
      cnt_ff      <= cnt_in;
      ms_ff       <= ms_in;
      err_ff      <= err_in;
      nint_ff     <= nint_in;
      diff_ff     <= diff_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      dquo_ff     <= dquo_in;
      drem_ff     <= drem_in;
      dden_ff     <= dden_in;
      dneg_ff     <= dneg_in;
   end

endmodule
